FILE: sv/mrf_pkg.sv
`default_nettype none

package mrf_pkg;

	// Clamp on the payload byte count of a write-multiple frame
	localparam int unsigned MAX_DATA_BYTES_DEF = 246;

	// Depth of the command queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [7:0] BIT_READ_CODE_RST     = 8'd1;
	localparam logic [7:0] WRITE_SINGLE_CODE_RST = 8'd6;
	localparam logic [7:0] WRITE_MULTI_CODE_RST  = 8'd16;

	// CRC-16/MODBUS
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef enum logic [2:0] {
		REQ_READ        = 3'd0,
		REQ_READ_BITS   = 3'd1,
		REQ_WRITE_ONE   = 3'd2,
		REQ_WRITE_MULTI = 3'd3,
		REQ_PAYLOAD     = 3'd4
	} req_kind_t;

	typedef enum logic [1:0] {
		CFG_BIT_READ     = 2'd0,
		CFG_WRITE_SINGLE = 2'd1,
		CFG_WRITE_MULTI  = 2'd2
	} cfg_idx_t;

	// One queued piece of work for the back end: data bytes, then optionally the CRC
	typedef struct packed {
		logic [7:0][7:0] data;
		logic [2:0]      n_data;
		logic            add_crc;
		logic            fresh;
	} frame_cmd_t;

	// One byte through the reflected CRC
	function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: sv/mrf_ifs.sv
`default_nettype none

// Request channel
interface mrf_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [7:0]  slave_addr;
	logic [7:0]  func_code;
	logic [15:0] reg_addr;
	logic [15:0] count_or_value;
	logic [7:0]  data_byte;

	modport source (
		output valid, req_type, slave_addr, func_code, reg_addr, count_or_value, data_byte,
		input  ready
	);
	modport sink (
		input  valid, req_type, slave_addr, func_code, reg_addr, count_or_value, data_byte,
		output ready
	);
endinterface

// Byte stream channel
interface mrf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source (
		output valid, out_byte, last,
		input  ready
	);
	modport sink (
		input  valid, out_byte, last,
		output ready
	);
endinterface

`default_nettype wire

FILE: sv/mrf_front.sv
`default_nettype none

module mrf_front #(
	parameter int unsigned MAX_DATA_BYTES = mrf_pkg::MAX_DATA_BYTES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	mrf_req_if.sink                                req,
	input  wire logic                              cfg_we,
	input  wire logic [mrf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [mrf_pkg::CFG_DATA_W-1:0]    cfg_data,
	output mrf_pkg::frame_cmd_t                    cmd,
	output logic                                   push,
	input  wire logic                              full
);
	import mrf_pkg::*;

	logic [7:0] bit_read_code_q;
	logic [7:0] write_single_code_q;
	logic [7:0] write_multi_code_q;
	logic [7:0] bytes_left_q;
	logic       in_payload_q;

	logic       acc;
	logic       produce;
	logic [7:0] code;
	logic [7:0] cnt;

	assign req.ready = !full;
	assign acc       = req.valid && req.ready;
	assign push      = acc && produce;

	// Clamped payload byte count
	assign cnt = (req.count_or_value > 16'(MAX_DATA_BYTES)) ? 8'(MAX_DATA_BYTES)
		: req.count_or_value[7:0];

	// Function code of a plain request
	always_comb begin
		case (req.req_type)
			REQ_READ:      code = req.func_code;
			REQ_READ_BITS: code = bit_read_code_q;
			default:       code = write_single_code_q;
		endcase
	end

	// Classify the item and build the command
	always_comb begin
		cmd     = '0;
		produce = 1'b0;
		case (req.req_type)
			REQ_READ, REQ_READ_BITS, REQ_WRITE_ONE: begin
				produce      = 1'b1;
				cmd.data[0]  = req.slave_addr;
				cmd.data[1]  = code;
				cmd.data[2]  = req.reg_addr[15:8];
				cmd.data[3]  = req.reg_addr[7:0];
				cmd.data[4]  = req.count_or_value[15:8];
				cmd.data[5]  = req.count_or_value[7:0];
				cmd.n_data   = 3'd6;
				cmd.add_crc  = 1'b1;
				cmd.fresh    = 1'b1;
			end
			REQ_WRITE_MULTI: begin
				produce      = 1'b1;
				cmd.data[0]  = req.slave_addr;
				cmd.data[1]  = write_multi_code_q;
				cmd.data[2]  = req.reg_addr[15:8];
				cmd.data[3]  = req.reg_addr[7:0];
				cmd.data[4]  = 8'h00;
				cmd.data[5]  = {1'b0, cnt[7:1]};
				cmd.data[6]  = cnt;
				cmd.n_data   = 3'd7;
				cmd.add_crc  = (cnt == 8'd0);
				cmd.fresh    = 1'b1;
			end
			REQ_PAYLOAD: begin
				produce      = in_payload_q;
				cmd.data[0]  = req.data_byte;
				cmd.n_data   = 3'd1;
				cmd.add_crc  = (bytes_left_q == 8'd1);
				cmd.fresh    = 1'b0;
			end
			default: ;
		endcase
	end

	// Open frame tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			in_payload_q <= 1'b0;
		end else if (acc) begin
			case (req.req_type)
				REQ_READ, REQ_READ_BITS, REQ_WRITE_ONE: begin
					bytes_left_q <= '0;
					in_payload_q <= 1'b0;
				end
				REQ_WRITE_MULTI: begin
					bytes_left_q <= cnt;
					in_payload_q <= (cnt != 8'd0);
				end
				REQ_PAYLOAD: begin
					if (in_payload_q) begin
						bytes_left_q <= bytes_left_q - 8'd1;
						if (bytes_left_q == 8'd1) begin
							in_payload_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_read_code_q     <= BIT_READ_CODE_RST;
			write_single_code_q <= WRITE_SINGLE_CODE_RST;
			write_multi_code_q  <= WRITE_MULTI_CODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BIT_READ:     bit_read_code_q     <= cfg_data;
				CFG_WRITE_SINGLE: write_single_code_q <= cfg_data;
				CFG_WRITE_MULTI:  write_multi_code_q  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: sv/mrf_queue.sv
`default_nettype none

module mrf_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire mrf_pkg::frame_cmd_t cmd_in,
	input  wire logic                pop,
	output mrf_pkg::frame_cmd_t      cmd_out,
	output logic                     empty,
	output logic                     full
);
	import mrf_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	frame_cmd_t         entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign cmd_out = entry_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue read while empty");
	a_ptrs_empty: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> (wr_ptr_q == rd_ptr_q)) else $error("pointers disagree with fill level");
`endif

endmodule

`default_nettype wire

FILE: sv/mrf_back.sv
`default_nettype none

module mrf_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mrf_pkg::frame_cmd_t head,
	input  wire logic                empty,
	output logic                     pop,
	mrf_byte_if.source               tx
);
	import mrf_pkg::*;

	logic [3:0]  idx_q;
	logic [15:0] crc_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;

	logic        adv;
	logic [3:0]  total;
	logic [15:0] crc_base;
	logic        is_data;
	logic        is_crc_lo;
	logic [7:0]  next_byte;
	logic        next_last;

	assign tx.valid    = out_valid_q;
	assign tx.out_byte = out_byte_q;
	assign tx.last     = out_last_q;

	// Step through the head command when the output register is free
	assign adv      = !empty && (!out_valid_q || tx.ready);
	assign total    = {1'b0, head.n_data} + (head.add_crc ? 4'd2 : 4'd0);
	assign pop      = adv && (idx_q == total - 4'd1);
	assign crc_base = (head.fresh && idx_q == 4'd0) ? CRC_INIT : crc_q;
	assign is_data  = (idx_q < {1'b0, head.n_data});
	assign is_crc_lo = (idx_q == {1'b0, head.n_data});

	// Byte selection: data, CRC low, CRC high
	always_comb begin
		if (is_data) begin
			next_byte = head.data[idx_q[2:0]];
			next_last = 1'b0;
		end else if (is_crc_lo) begin
			next_byte = crc_base[7:0];
			next_last = 1'b0;
		end else begin
			next_byte = crc_base[15:8];
			next_last = 1'b1;
		end
	end

	// Sequencer and running CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			crc_q <= CRC_INIT;
		end else if (adv) begin
			idx_q <= pop ? 4'd0 : idx_q + 4'd1;
			if (is_data) begin
				crc_q <= crc_next(crc_base, next_byte);
			end else if (!is_crc_lo) begin
				crc_q <= CRC_INIT;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (tx.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= next_byte;
			out_last_q <= next_last;
		end
	end

`ifndef SYNTHESIS
	a_idx_in_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (idx_q < total)) else $error("sequencer ran past its command");
	a_idx_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (idx_q == 4'd0)) else $error("sequencer did not restart after a command");
	a_crc_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && next_last) |=> (crc_q == CRC_INIT)) else $error("CRC not reset after frame");
`endif

endmodule

`default_nettype wire

FILE: sv/modbus_rtu_request_framer.sv
// Modbus RTU request framer.
// Channel req (valid/ready) takes one item per cycle until the queue fills:
// a whole request (read, read bits, write one, write-multiple header) or one payload byte.
// Channel tx (valid/ready) gives the frame bytes in wire order, CRC-16/MODBUS
// low byte first, with last set on the final CRC byte of each frame.
// The cfg port (cfg_we, cfg_index, cfg_data) sets the function codes used
// for bit reads, single writes and multiple writes; write it while idle.
// The first byte of an item passes through the command queue and then the
// output register before it is valid on tx.
// Throughput: the byte sequencer emits one byte per cycle while tx is ready.
// A read or write-one gives 8 bytes, a write-multiple header 7 (9 when its
// byte count is zero), a payload byte 1 (3 when it closes the frame). A
// two-entry command queue sits between the classifier and the sequencer, so
// payload items stream at one per cycle while tx is ready.
// Reset clears the queue, the open-frame state and the output register and
// restores the default function codes (1, 6, 16).
// When tx stalls the output register holds its byte, the queue fills and
// req.ready falls; nothing is lost.
`default_nettype none

module modbus_rtu_request_framer #(
	parameter int unsigned MAX_DATA_BYTES = mrf_pkg::MAX_DATA_BYTES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	mrf_req_if.sink                                req,
	mrf_byte_if.source                             tx,
	input  wire logic                              cfg_we,
	input  wire logic [mrf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [mrf_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import mrf_pkg::*;

	frame_cmd_t cmd_in;
	frame_cmd_t cmd_head;
	logic       push;
	logic       pop;
	logic       empty;
	logic       full;

	mrf_front #(
		.MAX_DATA_BYTES (MAX_DATA_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_in),
		.push      (push),
		.full      (full)
	);

	mrf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.cmd_in  (cmd_in),
		.pop     (pop),
		.cmd_out (cmd_head),
		.empty   (empty),
		.full    (full)
	);

	mrf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (cmd_head),
		.empty  (empty),
		.pop    (pop),
		.tx     (tx)
	);

endmodule

`default_nettype wire

FILE: bench/modbus_rtu_request_framer_tb.sv
`timescale 1ns / 1ps

module modbus_rtu_request_framer_tb;
	import mrf_pkg::*;

	// Request kinds that the framer ignores
	localparam logic [2:0] REQ_RSVD_A = 3'd5;
	localparam logic [2:0] REQ_RSVD_B = 3'd6;
	localparam logic [2:0] REQ_RSVD_C = 3'd7;

	localparam int unsigned MAX_BYTES = MAX_DATA_BYTES_DEF;
	localparam int IDLE_PCT = 17;
	localparam int SETTLE_CYCLES = 10;
	localparam int BURST_ITEMS = 34;
	localparam int LONG_FRAME_BYTES = 30;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  slave_addr;
		logic [7:0]  func_code;
		logic [15:0] reg_addr;
		logic [15:0] count_or_value;
		logic [7:0]  data_byte;
	} request_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} wire_byte_t;

	// How a row of the directed table is checked
	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_NONE,
		ROW_CRC
	} row_check_t;

	typedef struct packed {
		request_t    req;
		row_check_t  check;
		logic [15:0] crc;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// No idling on either side while set
	bit quiet;
	int errors;
	int sent_count;

	// Predictor copy of the registers and the frame state
	logic [7:0]  code_bit_read;
	logic [7:0]  code_write_one;
	logic [7:0]  code_write_multi;
	logic [15:0] crc_run;
	logic [7:0]  payload_left;
	bit          frame_open;

	wire_byte_t new_bytes[$];
	wire_byte_t pending_bytes[$];
	dir_row_t   dir_rows[$];

	mrf_req_if  req_ch ();
	mrf_byte_if tx_ch ();

	modbus_rtu_request_framer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.tx        (tx_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Reflected CRC-16, polynomial 0xA001, one byte
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		return c;
	endfunction

	task automatic put_data(input logic [7:0] b);
		new_bytes.push_back('{data: b, last: 1'b0});
		crc_run = crc_step(crc_run, b);
	endtask

	task automatic put_crc();
		new_bytes.push_back('{data: crc_run[7:0], last: 1'b0});
		new_bytes.push_back('{data: crc_run[15:8], last: 1'b1});
		crc_run = 16'hFFFF;
	endtask

	// Frame bytes caused by one request, into new_bytes
	task automatic predict_frame(input request_t r);
		logic [7:0]  code;
		logic [15:0] cnt;
		logic [15:0] regs;
		new_bytes.delete();
		case (r.kind)
			REQ_PAYLOAD: begin
				if (frame_open) begin
					put_data(r.data_byte);
					payload_left = payload_left - 8'd1;
					if (payload_left == 8'd0) begin
						put_crc();
						frame_open = 1'b0;
					end
				end
			end
			REQ_READ, REQ_READ_BITS, REQ_WRITE_ONE: begin
				frame_open = 1'b0;
				payload_left = 8'd0;
				crc_run = 16'hFFFF;
				if (r.kind == REQ_READ)
					code = r.func_code;
				else if (r.kind == REQ_READ_BITS)
					code = code_bit_read;
				else
					code = code_write_one;
				put_data(r.slave_addr);
				put_data(code);
				put_data(r.reg_addr[15:8]);
				put_data(r.reg_addr[7:0]);
				put_data(r.count_or_value[15:8]);
				put_data(r.count_or_value[7:0]);
				put_crc();
			end
			REQ_WRITE_MULTI: begin
				frame_open = 1'b0;
				payload_left = 8'd0;
				crc_run = 16'hFFFF;
				cnt = (r.count_or_value > MAX_BYTES) ? 16'(MAX_BYTES) : r.count_or_value;
				regs = cnt >> 1;
				put_data(r.slave_addr);
				put_data(code_write_multi);
				put_data(r.reg_addr[15:8]);
				put_data(r.reg_addr[7:0]);
				put_data(regs[15:8]);
				put_data(regs[7:0]);
				put_data(cnt[7:0]);
				if (cnt == 16'd0)
					put_crc();
				else begin
					payload_left = cnt[7:0];
					frame_open = 1'b1;
				end
			end
			default: ;
		endcase
	endtask

	// One item onto the request channel, returns at its acceptance edge
	task automatic drive_request(input request_t r);
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.req_type       <= r.kind;
		req_ch.slave_addr     <= r.slave_addr;
		req_ch.func_code      <= r.func_code;
		req_ch.reg_addr       <= r.reg_addr;
		req_ch.count_or_value <= r.count_or_value;
		req_ch.data_byte      <= r.data_byte;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	task automatic issue(input request_t r);
		drive_request(r);
		predict_frame(r);
		sent_count++;
		foreach (new_bytes[i])
			pending_bytes.push_back(new_bytes[i]);
	endtask

	function automatic request_t random_request(input logic [2:0] kind);
		request_t r;
		r.kind           = kind;
		r.slave_addr     = 8'($urandom);
		r.func_code      = 8'($urandom);
		r.reg_addr       = 16'($urandom);
		r.count_or_value = 16'($urandom);
		r.data_byte      = 8'($urandom);
		return r;
	endfunction

	function automatic dir_row_t row(input logic [2:0] kind, input logic [7:0] slave,
			input logic [7:0] fc, input logic [15:0] ra, input logic [15:0] cv,
			input logic [7:0] db, input row_check_t chk, input logic [15:0] crc);
		dir_row_t d;
		d.req   = '{kind: kind, slave_addr: slave, func_code: fc, reg_addr: ra,
			count_or_value: cv, data_byte: db};
		d.check = chk;
		d.crc   = crc;
		return d;
	endfunction

	// Drop valid, drain every expected byte, then let the pipe settle
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_codes(input logic [7:0] br, input logic [7:0] ws, input logic [7:0] wm);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_BIT_READ;
		cfg_data  <= br;
		@(posedge clk);
		cfg_index <= CFG_WRITE_SINGLE;
		cfg_data  <= ws;
		@(posedge clk);
		cfg_index <= CFG_WRITE_MULTI;
		cfg_data  <= wm;
		@(posedge clk);
		cfg_we <= 1'b0;
		code_bit_read    = br;
		code_write_one   = ws;
		code_write_multi = wm;
	endtask

	// Random traffic: mostly complete write-multiple frames, plus noise
	task automatic run_burst(input int quota, input bit full_frame);
		request_t r;
		int       pick;
		int       n;
		sent_count = 0;
		while (sent_count < quota) begin
			pick = $urandom_range(0, 99);
			if (full_frame) begin
				// long frame, every payload byte up to the close
				r = random_request(REQ_WRITE_MULTI);
				r.count_or_value = 16'(LONG_FRAME_BYTES);
				issue(r);
				for (int i = 0; i < LONG_FRAME_BYTES; i++)
					issue(random_request(REQ_PAYLOAD));
				full_frame = 1'b0;
			end else if (pick < 55) begin
				r = random_request(REQ_WRITE_MULTI);
				if ($urandom_range(0, 9) != 0)
					r.count_or_value = 16'($urandom_range(0, 12));
				issue(r);
				n = (r.count_or_value > MAX_BYTES) ? $urandom_range(1, 6) : r.count_or_value;
				for (int i = 0; i < n; i++) begin
					pick = $urandom_range(0, 99);
					if (pick < 4)
						break;
					if (pick < 8)
						issue(random_request(3'($urandom_range(REQ_RSVD_A, REQ_RSVD_C))));
					issue(random_request(REQ_PAYLOAD));
				end
			end else if (pick < 80)
				issue(random_request(3'($urandom_range(REQ_READ, REQ_WRITE_ONE))));
			else if (pick < 90)
				issue(random_request(REQ_PAYLOAD));
			else
				issue(random_request(3'($urandom_range(REQ_RSVD_A, REQ_RSVD_C))));
		end
	endtask

	// Output side: check each accepted byte, then pick the next ready
	always @(posedge clk) begin
		wire_byte_t want;
		if (arst_n && tx_ch.valid && tx_ch.ready) begin
			if (pending_bytes.size() == 0) begin
				$error("out_byte: expected none, actual %h (last %b)", tx_ch.out_byte,
					tx_ch.last);
				errors++;
			end else begin
				want = pending_bytes.pop_front();
				if (tx_ch.out_byte !== want.data) begin
					$error("out_byte: expected %h, actual %h", want.data, tx_ch.out_byte);
					errors++;
				end
				if (tx_ch.last !== want.last) begin
					$error("last: expected %b, actual %b", want.last, tx_ch.last);
					errors++;
				end
			end
		end
		tx_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	initial begin
		request_t r;
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = CFG_BIT_READ;
		cfg_data              = 8'h00;
		req_ch.valid          = 1'b0;
		req_ch.req_type       = REQ_READ;
		req_ch.slave_addr     = 8'h00;
		req_ch.func_code      = 8'h00;
		req_ch.reg_addr       = 16'h0000;
		req_ch.count_or_value = 16'h0000;
		req_ch.data_byte      = 8'h00;
		tx_ch.ready           = 1'b0;
		quiet                 = 1'b0;
		errors                = 0;

		// predictor after reset
		code_bit_read    = BIT_READ_CODE_RST;
		code_write_one   = WRITE_SINGLE_CODE_RST;
		code_write_multi = WRITE_MULTI_CODE_RST;
		crc_run          = 16'hFFFF;
		payload_left     = 8'd0;
		frame_open       = 1'b0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, reset function codes
		dir_rows.push_back(row(REQ_READ, 8'h01, 8'h03, 16'h0000, 16'h0001, 8'hA5,
			ROW_CRC, 16'h0A84));
		dir_rows.push_back(row(REQ_READ, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00,
			ROW_PREDICT, 16'h0));
		dir_rows.push_back(row(REQ_READ, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF,
			ROW_PREDICT, 16'h0));
		dir_rows.push_back(row(REQ_READ_BITS, 8'h11, 8'h5A, 16'h0013, 16'h0025, 8'h3C,
			ROW_PREDICT, 16'h0));
		dir_rows.push_back(row(REQ_WRITE_ONE, 8'h01, 8'hC3, 16'h0001, 16'h0003, 8'h00,
			ROW_PREDICT, 16'h0));
		dir_rows.push_back(row(REQ_WRITE_ONE, 8'hFF, 8'h00, 16'hFFFF, 16'hFFFF, 8'hFF,
			ROW_PREDICT, 16'h0));
		// stray payload and unused kinds give nothing
		dir_rows.push_back(row(REQ_PAYLOAD, 8'h12, 8'h34, 16'h5678, 16'h0001, 8'h77,
			ROW_NONE, 16'h0));
		dir_rows.push_back(row(REQ_RSVD_A, 8'hFF, 8'hFF, 16'hFFFF, 16'h0000, 8'hFF,
			ROW_NONE, 16'h0));
		dir_rows.push_back(row(REQ_RSVD_B, 8'h00, 8'h00, 16'h0000, 16'h0005, 8'h00,
			ROW_NONE, 16'h0));
		dir_rows.push_back(row(REQ_RSVD_C, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF,
			ROW_NONE, 16'h0));
		// zero byte count closes at once
		dir_rows.push_back(row(REQ_WRITE_MULTI, 8'h0A, 8'h00, 16'h1234, 16'h0000, 8'h99,
			ROW_PREDICT, 16'h0));
		dir_rows.push_back(row(REQ_WRITE_MULTI, 8'h0B, 8'h00, 16'hFFFF, 16'h0001, 8'h00,
			ROW_PREDICT, 16'h0));
		dir_rows.push_back(row(REQ_PAYLOAD, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'hFF,
			ROW_PREDICT, 16'h0));
		// odd count, unused kind inside the open frame
		dir_rows.push_back(row(REQ_WRITE_MULTI, 8'hF0, 8'h00, 16'h0100, 16'h0003, 8'h00,
			ROW_PREDICT, 16'h0));
		dir_rows.push_back(row(REQ_PAYLOAD, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00,
			ROW_PREDICT, 16'h0));
		dir_rows.push_back(row(REQ_RSVD_C, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'hEE,
			ROW_NONE, 16'h0));
		dir_rows.push_back(row(REQ_PAYLOAD, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h55,
			ROW_PREDICT, 16'h0));
		dir_rows.push_back(row(REQ_PAYLOAD, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'hAA,
			ROW_PREDICT, 16'h0));
		dir_rows.push_back(row(REQ_PAYLOAD, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h01,
			ROW_NONE, 16'h0));
		// clamped count, abandoned by a new request
		dir_rows.push_back(row(REQ_WRITE_MULTI, 8'h21, 8'h00, 16'h8000, 16'd247, 8'h00,
			ROW_PREDICT, 16'h0));
		dir_rows.push_back(row(REQ_PAYLOAD, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h3C,
			ROW_PREDICT, 16'h0));
		dir_rows.push_back(row(REQ_READ, 8'h22, 8'h04, 16'h00FF, 16'h007D, 8'h00,
			ROW_PREDICT, 16'h0));
		dir_rows.push_back(row(REQ_PAYLOAD, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'hC3,
			ROW_NONE, 16'h0));
		dir_rows.push_back(row(REQ_WRITE_MULTI, 8'h23, 8'h00, 16'h0001, 16'hFFFF, 8'h00,
			ROW_PREDICT, 16'h0));
		dir_rows.push_back(row(REQ_WRITE_ONE, 8'h24, 8'h00, 16'hFF00, 16'h00FF, 8'h00,
			ROW_PREDICT, 16'h0));

		foreach (dir_rows[i]) begin
			drive_request(dir_rows[i].req);
			predict_frame(dir_rows[i].req);
			if (dir_rows[i].check == ROW_NONE)
				new_bytes.delete();
			else if (dir_rows[i].check == ROW_CRC && new_bytes.size() == 8) begin
				new_bytes[6].data = dir_rows[i].crc[7:0];
				new_bytes[7].data = dir_rows[i].crc[15:8];
			end
			foreach (new_bytes[j])
				pending_bytes.push_back(new_bytes[j]);
		end

		// random phases under different function codes
		wait_idle();
		write_codes(8'h00, 8'h00, 8'h00);
		quiet = 1'b1;
		run_burst(BURST_ITEMS, 1'b0);
		wait_idle();
		quiet = 1'b0;
		write_codes(8'hFF, 8'hFF, 8'hFF);
		run_burst(BURST_ITEMS, 1'b1);
		wait_idle();
		write_codes(8'($urandom), 8'($urandom), 8'($urandom));
		run_burst(BURST_ITEMS, 1'b0);
		wait_idle();
		write_codes(BIT_READ_CODE_RST, WRITE_SINGLE_CODE_RST, WRITE_MULTI_CODE_RST);
		run_burst(BURST_ITEMS, 1'b0);

		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_bytes.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
